>>> sv/wrsv_pkg.sv
`timescale 1ns / 1ps

package wrsv_pkg;

  // field widths and fixed-point formats
  localparam int unsigned ITER_BITS  = 9;
  localparam int unsigned WIN_BITS   = 9;
  localparam int unsigned CMP_W      = (ITER_BITS > WIN_BITS) ? ITER_BITS : WIN_BITS;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned COEF_W     = 31;
  localparam int unsigned COEF_FRAC  = 29;
  localparam int unsigned SCALE_FRAC = 24;
  localparam int unsigned PROD_W     = COORD_W + COEF_W;
  localparam int unsigned DPROD_W    = DIST_W + COEF_W;
  localparam int unsigned ACC_W      = 64;

  // steps: three rotations then five multipliers
  localparam int unsigned NUM_ROT   = 3;
  localparam int unsigned NUM_MUL   = 5;
  localparam int unsigned NUM_STEPS = NUM_ROT + NUM_MUL;

  // configuration port
  localparam int unsigned CFG_DATA_W = 2 * COEF_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WIN_DEF_W  = 6 * WIN_BITS;
  localparam int unsigned EN_LSB     = 6 * WIN_BITS;

  localparam logic signed [ACC_W-1:0] COORD_MAX =
    {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] COORD_MIN =
    {{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] DIST_MAX = {{(ACC_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_YZ_COEFS,
    REG_XZ_COEFS,
    REG_XY_COEFS,
    REG_WIN_ABC,
    REG_WIN_DEF,
    REG_SCALES_12,
    REG_SCALES_34,
    REG_SCALE_5
  } reg_e;

  typedef enum logic [1:0] {
    PLANE_YZ,
    PLANE_XZ,
    PLANE_XY
  } plane_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] coord_w;
    logic [DIST_W-1:0]         dist_factor;
    logic [ITER_BITS-1:0]      iteration;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_w;
    logic [DIST_W-1:0]         out_dist_factor;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] w;
    logic [DIST_W-1:0]         de;
  } point_t;

  // one pipeline slot: valid, remaining step enables (lsb is the next step), point
  typedef struct packed {
    logic                 valid;
    logic [NUM_STEPS-1:0] act;
    point_t               pt;
  } stage_t;

  // round half up, arithmetic shift, saturate to a signed coordinate
  function automatic logic [COORD_W-1:0] round_sat_s(input logic signed [ACC_W-1:0] acc,
                                                     input int unsigned frac);
    logic signed [ACC_W-1:0] r;
    r = acc + ($signed(ACC_W'(1)) <<< (frac - 1));
    r = r >>> frac;
    if (r > COORD_MAX) begin
      return COORD_MAX[COORD_W-1:0];
    end else if (r < COORD_MIN) begin
      return COORD_MIN[COORD_W-1:0];
    end
    return r[COORD_W-1:0];
  endfunction

  // round half up, shift, saturate to the unsigned distance factor
  function automatic logic [DIST_W-1:0] round_sat_u(input logic [ACC_W-1:0] acc,
                                                    input int unsigned frac);
    logic [ACC_W-1:0] r;
    r = (acc + (ACC_W'(1) << (frac - 1))) >> frac;
    if (r > DIST_MAX) begin
      return DIST_MAX[DIST_W-1:0];
    end
    return r[DIST_W-1:0];
  endfunction

endpackage

>>> sv/wrsv_window.sv
`timescale 1ns / 1ps

module wrsv_window (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  wrsv_pkg::in_t                        word_i,
  input  logic [wrsv_pkg::CFG_DATA_W-1:0]      win_abc_i,
  input  logic [wrsv_pkg::WIN_DEF_W-1:0]       win_def_i,
  output wrsv_pkg::stage_t                     stage_o
);

  localparam int unsigned PAIR_W = 2 * wrsv_pkg::WIN_BITS;

  function automatic logic in_win(input logic [PAIR_W-1:0] pair,
                                  input logic [wrsv_pkg::CMP_W-1:0] it);
    logic [wrsv_pkg::CMP_W-1:0] lo;
    logic [wrsv_pkg::CMP_W-1:0] hi;
    lo = wrsv_pkg::CMP_W'(pair[wrsv_pkg::WIN_BITS-1:0]);
    hi = wrsv_pkg::CMP_W'(pair[PAIR_W-1:wrsv_pkg::WIN_BITS]);
    return (it >= lo) && (it < hi);
  endfunction

  logic [wrsv_pkg::CMP_W-1:0]     it;
  logic [wrsv_pkg::NUM_STEPS-1:0] en;
  logic [wrsv_pkg::NUM_STEPS-1:0] act_d;
  logic                           win_a, win_b, win_c, win_d, win_e, win_f;
  wrsv_pkg::stage_t               stage_q;

  assign it = wrsv_pkg::CMP_W'(word_i.iteration);
  assign en = win_abc_i[wrsv_pkg::EN_LSB +: wrsv_pkg::NUM_STEPS];

  assign win_a = in_win(win_abc_i[0*PAIR_W +: PAIR_W], it);
  assign win_b = in_win(win_abc_i[1*PAIR_W +: PAIR_W], it);
  assign win_c = in_win(win_abc_i[2*PAIR_W +: PAIR_W], it);
  assign win_d = in_win(win_def_i[0*PAIR_W +: PAIR_W], it);
  assign win_e = in_win(win_def_i[1*PAIR_W +: PAIR_W], it);
  assign win_f = in_win(win_def_i[2*PAIR_W +: PAIR_W], it);

  // rotations use windows a, b, c; multipliers use b through f, so b and c are shared
  assign act_d = {en[7] & win_f, en[6] & win_e, en[5] & win_d, en[4] & win_c,
                  en[3] & win_b, en[2] & win_c, en[1] & win_b, en[0] & win_a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q.valid <= valid_i;
      stage_q.act   <= act_d;
      stage_q.pt.x  <= word_i.coord_x;
      stage_q.pt.y  <= word_i.coord_y;
      stage_q.pt.z  <= word_i.coord_z;
      stage_q.pt.w  <= word_i.coord_w;
      stage_q.pt.de <= word_i.dist_factor;
    end
  end

  assign stage_o = stage_q;

endmodule

>>> sv/wrsv_rotate.sv
`timescale 1ns / 1ps

module wrsv_rotate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wrsv_pkg::plane_e                plane_i,
  input  logic [wrsv_pkg::CFG_DATA_W-1:0] coefs_i,
  input  wrsv_pkg::stage_t                stage_i,
  output wrsv_pkg::stage_t                stage_o
);

  typedef struct packed {
    logic signed [wrsv_pkg::PROD_W-1:0] uc;
    logic signed [wrsv_pkg::PROD_W-1:0] vs;
    logic signed [wrsv_pkg::PROD_W-1:0] vc;
    logic signed [wrsv_pkg::PROD_W-1:0] us;
  } rot_prod_t;

  logic signed [wrsv_pkg::COORD_W-1:0] u, v;
  logic signed [wrsv_pkg::COEF_W-1:0]  c, s;
  rot_prod_t                           prod_d, prod_q;
  wrsv_pkg::stage_t                    mid_q;
  logic signed [wrsv_pkg::ACC_W-1:0]   acc_u, acc_v;
  logic [wrsv_pkg::COORD_W-1:0]        nu, nv;
  wrsv_pkg::stage_t                    out_d, out_q;

  assign c = $signed(coefs_i[wrsv_pkg::CFG_DATA_W-1:wrsv_pkg::COEF_W]);
  assign s = $signed(coefs_i[wrsv_pkg::COEF_W-1:0]);

  // first half: pick the plane and form the four products
  always_comb begin
    unique case (plane_i)
      wrsv_pkg::PLANE_YZ: begin
        u = stage_i.pt.y;
        v = stage_i.pt.z;
      end
      wrsv_pkg::PLANE_XZ: begin
        u = stage_i.pt.x;
        v = stage_i.pt.z;
      end
      wrsv_pkg::PLANE_XY: begin
        u = stage_i.pt.x;
        v = stage_i.pt.y;
      end
      default: begin
        u = stage_i.pt.x;
        v = stage_i.pt.y;
      end
    endcase
    prod_d.uc = u * c;
    prod_d.vs = v * s;
    prod_d.vc = v * c;
    prod_d.us = u * s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= '0;
      prod_q <= '0;
      out_q  <= '0;
    end else begin
      mid_q  <= stage_i;
      prod_q <= prod_d;
      out_q  <= out_d;
    end
  end

  // second half: sum, round, saturate, write back when the step is on
  assign acc_u = wrsv_pkg::ACC_W'(prod_q.uc) + wrsv_pkg::ACC_W'(prod_q.vs);
  assign acc_v = wrsv_pkg::ACC_W'(prod_q.vc) - wrsv_pkg::ACC_W'(prod_q.us);
  assign nu    = wrsv_pkg::round_sat_s(acc_u, wrsv_pkg::COEF_FRAC);
  assign nv    = wrsv_pkg::round_sat_s(acc_v, wrsv_pkg::COEF_FRAC);

  always_comb begin
    out_d       = mid_q;
    out_d.act   = mid_q.act >> 1;
    if (mid_q.act[0]) begin
      unique case (plane_i)
        wrsv_pkg::PLANE_YZ: begin
          out_d.pt.y = nu;
          out_d.pt.z = nv;
        end
        wrsv_pkg::PLANE_XZ: begin
          out_d.pt.x = nu;
          out_d.pt.z = nv;
        end
        wrsv_pkg::PLANE_XY: begin
          out_d.pt.x = nu;
          out_d.pt.y = nv;
        end
        default: begin
          out_d.pt.x = nu;
          out_d.pt.y = nv;
        end
      endcase
    end
  end

  assign stage_o = out_q;

  a_valid_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid == $past(stage_i.valid, 2))
    else $error("rotate stage lost or made up a word");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_q.valid && !mid_q.act[0] |=> out_q.pt == $past(mid_q.pt))
    else $error("inactive rotation changed the point");

endmodule

>>> sv/wrsv_scale.sv
`timescale 1ns / 1ps

module wrsv_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wrsv_pkg::COEF_W-1:0] scale_i,
  input  wrsv_pkg::stage_t            stage_i,
  output wrsv_pkg::stage_t            stage_o
);

  typedef struct packed {
    logic signed [wrsv_pkg::PROD_W-1:0] x;
    logic signed [wrsv_pkg::PROD_W-1:0] y;
    logic signed [wrsv_pkg::PROD_W-1:0] z;
    logic signed [wrsv_pkg::PROD_W-1:0] w;
    logic [wrsv_pkg::DPROD_W-1:0]       de;
  } sc_prod_t;

  logic signed [wrsv_pkg::COEF_W-1:0] scale_s;
  logic [wrsv_pkg::COEF_W-1:0]        mag;
  sc_prod_t                           prod_d, prod_q;
  wrsv_pkg::stage_t                   mid_q;
  wrsv_pkg::stage_t                   out_d, out_q;

  assign scale_s = $signed(scale_i);
  // most negative scale gives 2^30, which still fits unsigned
  assign mag     = scale_i[wrsv_pkg::COEF_W-1] ? wrsv_pkg::COEF_W'(-scale_i) : scale_i;

  always_comb begin
    prod_d.x  = stage_i.pt.x * scale_s;
    prod_d.y  = stage_i.pt.y * scale_s;
    prod_d.z  = stage_i.pt.z * scale_s;
    prod_d.w  = stage_i.pt.w * scale_s;
    prod_d.de = wrsv_pkg::DPROD_W'(stage_i.pt.de) * wrsv_pkg::DPROD_W'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= '0;
      prod_q <= '0;
      out_q  <= '0;
    end else begin
      mid_q  <= stage_i;
      prod_q <= prod_d;
      out_q  <= out_d;
    end
  end

  always_comb begin
    out_d     = mid_q;
    out_d.act = mid_q.act >> 1;
    if (mid_q.act[0]) begin
      out_d.pt.x  = wrsv_pkg::round_sat_s(wrsv_pkg::ACC_W'(prod_q.x), wrsv_pkg::SCALE_FRAC);
      out_d.pt.y  = wrsv_pkg::round_sat_s(wrsv_pkg::ACC_W'(prod_q.y), wrsv_pkg::SCALE_FRAC);
      out_d.pt.z  = wrsv_pkg::round_sat_s(wrsv_pkg::ACC_W'(prod_q.z), wrsv_pkg::SCALE_FRAC);
      out_d.pt.w  = wrsv_pkg::round_sat_s(wrsv_pkg::ACC_W'(prod_q.w), wrsv_pkg::SCALE_FRAC);
      out_d.pt.de = wrsv_pkg::round_sat_u(wrsv_pkg::ACC_W'(prod_q.de), wrsv_pkg::SCALE_FRAC);
    end
  end

  assign stage_o = out_q;

  a_valid_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid == $past(stage_i.valid, 2))
    else $error("scale stage lost or made up a word");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_q.valid && !mid_q.act[0] |=> out_q.pt == $past(mid_q.pt))
    else $error("inactive multiplier changed the point");

endmodule

>>> sv/windowed_rotate_scale_vec4_top.sv
`timescale 1ns / 1ps

// Fixed-point point transform for one fractal iteration: up to three plane
// rotations (y-z, x-z, x-y) and five uniform scalings, each gated by its enable
// bit and by an iteration window [start, stop), every step rounded and saturated.
// A word is taken at every clock edge where start is high; busy is never raised,
// so a new word may follow in every cycle. Each result appears on result_o for
// exactly one cycle with result_valid_o high, in input order. The receiver cannot
// hold results off and nothing is buffered. The pipeline is one register for the
// window decode plus two per step for the eight steps: a multiply register (four
// 32x31 products per rotation, five per scaling) then a sum, round and saturate
// register. Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i and should only change while no word is in flight.

module windowed_rotate_scale_vec4_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input word
  input  logic                            start,
  output logic                            busy,
  input  wrsv_pkg::in_t                   in_word_i,
  // result word
  output logic                            result_valid_o,
  output wrsv_pkg::out_t                  result_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [wrsv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wrsv_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LATENCY = 1 + 2 * wrsv_pkg::NUM_STEPS;

  // configuration registers
  logic [wrsv_pkg::CFG_DATA_W-1:0] rot_coefs_q [wrsv_pkg::NUM_ROT];
  logic [wrsv_pkg::CFG_DATA_W-1:0] win_abc_q;
  logic [wrsv_pkg::WIN_DEF_W-1:0]  win_def_q;
  logic [wrsv_pkg::CFG_DATA_W-1:0] scales_12_q;
  logic [wrsv_pkg::CFG_DATA_W-1:0] scales_34_q;
  logic [wrsv_pkg::COEF_W-1:0]     scale_5_q;

  // scale per multiplier, in step order
  logic [wrsv_pkg::COEF_W-1:0]     scale [wrsv_pkg::NUM_MUL];

  // pipeline slots between the units
  wrsv_pkg::stage_t                win_s;
  wrsv_pkg::stage_t                rot_s [wrsv_pkg::NUM_ROT];
  wrsv_pkg::stage_t                mul_s [wrsv_pkg::NUM_MUL];
  wrsv_pkg::stage_t                last_s;

  // the pipeline never stalls, so the block is always ready
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wrsv_pkg::NUM_ROT; i++) begin
        rot_coefs_q[i] <= '0;
      end
      win_abc_q   <= '0;
      win_def_q   <= '0;
      scales_12_q <= '0;
      scales_34_q <= '0;
      scale_5_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (wrsv_pkg::reg_e'(cfg_idx_i))
        wrsv_pkg::REG_YZ_COEFS:  rot_coefs_q[0] <= cfg_data_i;
        wrsv_pkg::REG_XZ_COEFS:  rot_coefs_q[1] <= cfg_data_i;
        wrsv_pkg::REG_XY_COEFS:  rot_coefs_q[2] <= cfg_data_i;
        wrsv_pkg::REG_WIN_ABC:   win_abc_q      <= cfg_data_i;
        wrsv_pkg::REG_WIN_DEF:   win_def_q      <= cfg_data_i[wrsv_pkg::WIN_DEF_W-1:0];
        wrsv_pkg::REG_SCALES_12: scales_12_q    <= cfg_data_i;
        wrsv_pkg::REG_SCALES_34: scales_34_q    <= cfg_data_i;
        wrsv_pkg::REG_SCALE_5:   scale_5_q      <= cfg_data_i[wrsv_pkg::COEF_W-1:0];
      endcase
    end
  end

  // scales one to four are packed two to a register, upper half first; scale five has its own
  assign scale[0] = scales_12_q[wrsv_pkg::CFG_DATA_W-1:wrsv_pkg::COEF_W];
  assign scale[1] = scales_12_q[wrsv_pkg::COEF_W-1:0];
  assign scale[2] = scales_34_q[wrsv_pkg::CFG_DATA_W-1:wrsv_pkg::COEF_W];
  assign scale[3] = scales_34_q[wrsv_pkg::COEF_W-1:0];
  assign scale[4] = scale_5_q;

  // window decode: one enable per step, registered with the word
  wrsv_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start),
    .word_i    (in_word_i),
    .win_abc_i (win_abc_q),
    .win_def_i (win_def_q),
    .stage_o   (win_s)
  );

  // rotations y-z, x-z, x-y in that order
  for (genvar i = 0; i < wrsv_pkg::NUM_ROT; i++) begin : g_rot
    wrsv_rotate u_rotate (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .plane_i (wrsv_pkg::plane_e'(i)),
      .coefs_i (rot_coefs_q[i]),
      .stage_i ((i == 0) ? win_s : rot_s[(i == 0) ? 0 : i-1]),
      .stage_o (rot_s[i])
    );
  end

  // multipliers one through five
  for (genvar i = 0; i < wrsv_pkg::NUM_MUL; i++) begin : g_mul
    wrsv_scale u_scale (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .scale_i (scale[i]),
      .stage_i ((i == 0) ? rot_s[wrsv_pkg::NUM_ROT-1] : mul_s[(i == 0) ? 0 : i-1]),
      .stage_o (mul_s[i])
    );
  end

  assign last_s = mul_s[wrsv_pkg::NUM_MUL-1];

  assign result_valid_o           = last_s.valid;
  assign result_o.out_x           = last_s.pt.x;
  assign result_o.out_y           = last_s.pt.y;
  assign result_o.out_z           = last_s.pt.z;
  assign result_o.out_w           = last_s.pt.w;
  assign result_o.out_dist_factor = last_s.pt.de;

  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a word taken at the pipeline latency");

  a_steps_used_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> last_s.act == '0)
    else $error("result left the pipeline with a step still pending");

endmodule

>>> tb/sv/windowed_rotate_scale_vec4_top_test.sv
`timescale 1ns / 1ps

module windowed_rotate_scale_vec4_top_test;

  // clock, reset and block ports
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  wrsv_pkg::in_t                   in_word_i = '0;
  logic                            result_valid_o;
  wrsv_pkg::out_t                  result_o;
  logic                            cfg_we_i = 1'b0;
  logic [wrsv_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [wrsv_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // shadow copy of the configuration registers
  logic [wrsv_pkg::CFG_DATA_W-1:0] cfg_regs [8];

  wrsv_pkg::in_t  pending_words [$];
  wrsv_pkg::out_t expected_points [$];
  int unsigned    idle_pct = 0;
  int             mismatch_count = 0;
  int             words_checked = 0;
  int             saturated_count = 0;
  int             settings_count = 0;

  windowed_rotate_scale_vec4_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_word_i     (in_word_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // fixed-point transform predictor
  // ---------------------------------------------------------------------------

  // add half an lsb, then floor
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // slot selects one start/stop pair of a window register, iteration in [start, stop)
  function automatic bit in_window(input logic [wrsv_pkg::WIN_DEF_W-1:0] win,
                                   input int slot,
                                   input logic [wrsv_pkg::ITER_BITS-1:0] it);
    logic [wrsv_pkg::WIN_BITS-1:0] lo;
    logic [wrsv_pkg::WIN_BITS-1:0] hi;
    lo = win[slot * 2 * wrsv_pkg::WIN_BITS +: wrsv_pkg::WIN_BITS];
    hi = win[slot * 2 * wrsv_pkg::WIN_BITS + wrsv_pkg::WIN_BITS +: wrsv_pkg::WIN_BITS];
    return (it >= lo) && (it < hi);
  endfunction

  function automatic wrsv_pkg::out_t transform_point(input wrsv_pkg::in_t word);
    longint                          p [4];
    longint                          de, sc, mag, u, v, c, s;
    logic [wrsv_pkg::ITER_BITS-1:0]  it;
    logic [wrsv_pkg::WIN_DEF_W-1:0]  win;
    logic [wrsv_pkg::CFG_DATA_W-1:0] abc;
    logic [wrsv_pkg::CFG_DATA_W-1:0] coefs;
    int                              slot, ua, va, r, m, k;
    wrsv_pkg::out_t                  res;
    p[0] = longint'($signed(word.coord_x));
    p[1] = longint'($signed(word.coord_y));
    p[2] = longint'($signed(word.coord_z));
    p[3] = longint'($signed(word.coord_w));
    de = longint'({32'h0, word.dist_factor});
    it = word.iteration;
    abc = cfg_regs[wrsv_pkg::REG_WIN_ABC];

    // rotations y-z, x-z, x-y with windows a, b, c
    for (r = 0; r < wrsv_pkg::NUM_ROT; r++) begin
      case (wrsv_pkg::plane_e'(r))
        wrsv_pkg::PLANE_YZ: begin ua = 1; va = 2; end
        wrsv_pkg::PLANE_XZ: begin ua = 0; va = 2; end
        default:            begin ua = 0; va = 1; end
      endcase
      if (abc[wrsv_pkg::EN_LSB + r] && in_window(abc[wrsv_pkg::WIN_DEF_W-1:0], r, it)) begin
        coefs = cfg_regs[wrsv_pkg::REG_YZ_COEFS + r];
        c = longint'($signed(coefs[2*wrsv_pkg::COEF_W-1:wrsv_pkg::COEF_W]));
        s = longint'($signed(coefs[wrsv_pkg::COEF_W-1:0]));
        u = p[ua];
        v = p[va];
        p[ua] = clamp_coord(round_shift(u * c + v * s, wrsv_pkg::COEF_FRAC));
        p[va] = clamp_coord(round_shift(v * c - u * s, wrsv_pkg::COEF_FRAC));
      end
    end

    // five uniform scalings with windows b to f
    for (m = 0; m < wrsv_pkg::NUM_MUL; m++) begin
      case (m)
        0: begin
          coefs = cfg_regs[wrsv_pkg::REG_SCALES_12];
          sc = longint'($signed(coefs[2*wrsv_pkg::COEF_W-1:wrsv_pkg::COEF_W]));
          win = abc[wrsv_pkg::WIN_DEF_W-1:0];
          slot = 1;
        end
        1: begin
          coefs = cfg_regs[wrsv_pkg::REG_SCALES_12];
          sc = longint'($signed(coefs[wrsv_pkg::COEF_W-1:0]));
          win = abc[wrsv_pkg::WIN_DEF_W-1:0];
          slot = 2;
        end
        2: begin
          coefs = cfg_regs[wrsv_pkg::REG_SCALES_34];
          sc = longint'($signed(coefs[2*wrsv_pkg::COEF_W-1:wrsv_pkg::COEF_W]));
          win = cfg_regs[wrsv_pkg::REG_WIN_DEF][wrsv_pkg::WIN_DEF_W-1:0];
          slot = 0;
        end
        3: begin
          coefs = cfg_regs[wrsv_pkg::REG_SCALES_34];
          sc = longint'($signed(coefs[wrsv_pkg::COEF_W-1:0]));
          win = cfg_regs[wrsv_pkg::REG_WIN_DEF][wrsv_pkg::WIN_DEF_W-1:0];
          slot = 1;
        end
        default: begin
          coefs = cfg_regs[wrsv_pkg::REG_SCALE_5];
          sc = longint'($signed(coefs[wrsv_pkg::COEF_W-1:0]));
          win = cfg_regs[wrsv_pkg::REG_WIN_DEF][wrsv_pkg::WIN_DEF_W-1:0];
          slot = 2;
        end
      endcase
      if (abc[wrsv_pkg::EN_LSB + wrsv_pkg::NUM_ROT + m] && in_window(win, slot, it)) begin
        for (k = 0; k < 4; k++) begin
          p[k] = clamp_coord(round_shift(p[k] * sc, wrsv_pkg::SCALE_FRAC));
        end
        mag = (sc < 0) ? -sc : sc;
        de = round_shift(de * mag, wrsv_pkg::SCALE_FRAC);
        if (de > 64'sd4294967295) begin
          de = 64'sd4294967295;
        end
      end
    end

    res.out_x = p[0][31:0];
    res.out_y = p[1][31:0];
    res.out_z = p[2][31:0];
    res.out_w = p[3][31:0];
    res.out_dist_factor = de[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic wrsv_pkg::in_t make_word(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [31:0] w,
                                              input logic [31:0] d,
                                              input logic [wrsv_pkg::ITER_BITS-1:0] it);
    wrsv_pkg::in_t word;
    word.coord_x = x;
    word.coord_y = y;
    word.coord_z = z;
    word.coord_w = w;
    word.dist_factor = d;
    word.iteration = it;
    return word;
  endfunction

  // full-range or arithmetically shifted down so that not every result saturates
  function automatic logic [31:0] rand_coord();
    int v;
    v = $urandom;
    if ($urandom_range(1)) begin
      v = v >>> $urandom_range(0, 14);
    end
    return v;
  endfunction

  function automatic wrsv_pkg::in_t rand_word();
    logic [31:0] d;
    d = $urandom;
    if ($urandom_range(1)) begin
      d = d >> $urandom_range(0, 18);
    end
    return make_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(), d,
                     wrsv_pkg::ITER_BITS'($urandom_range(0, (1 << wrsv_pkg::ITER_BITS) - 1)));
  endfunction

  function automatic logic [wrsv_pkg::COEF_W-1:0] rand_coef();
    int v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 1 << wrsv_pkg::COEF_FRAC);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        case ($urandom_range(3))
          0: v = 32'h3FFF_FFFF;
          1: v = 32'h4000_0000;
          2: v = 0;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      default: v = $urandom_range(1) ? (1 << wrsv_pkg::COEF_FRAC) : -(1 << wrsv_pkg::COEF_FRAC);
    endcase
    return v[wrsv_pkg::COEF_W-1:0];
  endfunction

  // scales mostly near unity so several steps in a row stay in range
  function automatic logic [wrsv_pkg::COEF_W-1:0] rand_scale();
    int v;
    case ($urandom_range(4))
      0: v = $urandom;
      1, 2: begin
        v = $urandom_range(0, 1 << (wrsv_pkg::SCALE_FRAC + 1));
        if ($urandom_range(1)) v = -v;
      end
      3: begin
        case ($urandom_range(3))
          0: v = 32'h3FFF_FFFF;
          1: v = 32'h4000_0000;
          2: v = 0;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      default: v = $urandom_range(1) ? (1 << wrsv_pkg::SCALE_FRAC) : -(1 << wrsv_pkg::SCALE_FRAC);
    endcase
    return v[wrsv_pkg::COEF_W-1:0];
  endfunction

  // {stop, start}
  function automatic logic [2*wrsv_pkg::WIN_BITS-1:0] rand_window();
    logic [wrsv_pkg::WIN_BITS-1:0] lo, hi;
    case ($urandom_range(3))
      0: begin
        lo = wrsv_pkg::WIN_BITS'($urandom);
        hi = wrsv_pkg::WIN_BITS'($urandom);
      end
      1: begin
        lo = wrsv_pkg::WIN_BITS'($urandom_range(0, 255));
        hi = lo + wrsv_pkg::WIN_BITS'($urandom_range(1, 256));
      end
      2: begin
        lo = '0;
        hi = '1;
      end
      default: begin
        // empty window, start at or above stop
        lo = wrsv_pkg::WIN_BITS'($urandom);
        hi = $urandom_range(1) ? lo : wrsv_pkg::WIN_BITS'($urandom_range(0, lo));
      end
    endcase
    return {hi, lo};
  endfunction

  // ---------------------------------------------------------------------------
  // configuration writes, only issued while nothing is in flight
  // ---------------------------------------------------------------------------

  task automatic write_reg(input wrsv_pkg::reg_e idx,
                           input logic [wrsv_pkg::CFG_DATA_W-1:0] data);
    logic [wrsv_pkg::CFG_DATA_W-1:0] val;
    val = data;
    if (idx == wrsv_pkg::REG_WIN_DEF) begin
      val = val & ((wrsv_pkg::CFG_DATA_W'(1) << wrsv_pkg::WIN_DEF_W) - 1);
    end
    if (idx == wrsv_pkg::REG_SCALE_5) begin
      val = val & ((wrsv_pkg::CFG_DATA_W'(1) << wrsv_pkg::COEF_W) - 1);
    end
    cfg_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input bit all_ones);
    logic [7:0] en;
    en = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
    write_reg(wrsv_pkg::REG_YZ_COEFS, all_ones ? '1 : {rand_coef(), rand_coef()});
    write_reg(wrsv_pkg::REG_XZ_COEFS, all_ones ? '1 : {rand_coef(), rand_coef()});
    write_reg(wrsv_pkg::REG_XY_COEFS, all_ones ? '1 : {rand_coef(), rand_coef()});
    write_reg(wrsv_pkg::REG_WIN_ABC, all_ones ? '1 :
              {en, rand_window(), rand_window(), rand_window()});
    write_reg(wrsv_pkg::REG_WIN_DEF, all_ones ? '1 :
              wrsv_pkg::CFG_DATA_W'({rand_window(), rand_window(), rand_window()}));
    write_reg(wrsv_pkg::REG_SCALES_12, all_ones ? '1 : {rand_scale(), rand_scale()});
    write_reg(wrsv_pkg::REG_SCALES_34, all_ones ? '1 : {rand_scale(), rand_scale()});
    write_reg(wrsv_pkg::REG_SCALE_5, all_ones ? '1 : wrsv_pkg::CFG_DATA_W'(rand_scale()));
    settings_count++;
  endtask

  // wait until every word is sent and every result is back, then let the pipe settle
  task automatic drain();
    while (pending_words.size() != 0 || start || expected_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one word per accepted start, random gaps by idle_pct
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_word_i <= '0;
    end else if (!start || !busy) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_word_i <= pending_words.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on acceptance, compare each result word in order
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    wrsv_pkg::out_t exp_pt;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_points.push_back(transform_point(in_word_i));
      end
      if (result_valid_o) begin
        if (expected_points.size() == 0) begin
          $error("result word with no word outstanding: %h", result_o);
          mismatch_count++;
        end else begin
          exp_pt = expected_points.pop_front();
          check_field("out_x", exp_pt.out_x, result_o.out_x);
          check_field("out_y", exp_pt.out_y, result_o.out_y);
          check_field("out_z", exp_pt.out_z, result_o.out_z);
          check_field("out_w", exp_pt.out_w, result_o.out_w);
          check_field("out_dist_factor", exp_pt.out_dist_factor, result_o.out_dist_factor);
          words_checked++;
          if (exp_pt.out_x inside {32'h7FFF_FFFF, 32'h8000_0000} ||
              exp_pt.out_y inside {32'h7FFF_FFFF, 32'h8000_0000} ||
              exp_pt.out_z inside {32'h7FFF_FFFF, 32'h8000_0000} ||
              exp_pt.out_w inside {32'h7FFF_FFFF, 32'h8000_0000} ||
              exp_pt.out_dist_factor == 32'hFFFF_FFFF) begin
            saturated_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < 8; i++) begin
      cfg_regs[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: every step disabled, words pass through
    idle_pct = 0;
    settings_count = 1;
    pending_words.push_back(make_word(0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'h1FF));
    pending_words.push_back(make_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 0, 9'h100));
    pending_words.push_back(make_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                      32'h5555_5555, 32'hAAAA_AAAA, 9'h155));
    drain();

    // directed settings: 30 and 45 degree rotations, extreme x-y coefficients,
    // window a [0,511), b [5,100), c [0,300), d empty with start equal to stop,
    // e [200,300), f empty with start above stop; scales 2, -0.5, max, min, 1
    write_reg(wrsv_pkg::REG_YZ_COEFS, {31'(464943848), 31'(268435456)});
    write_reg(wrsv_pkg::REG_XZ_COEFS, {31'(379625062), 31'(-379625062)});
    write_reg(wrsv_pkg::REG_XY_COEFS, {31'h3FFF_FFFF, 31'h4000_0000});
    write_reg(wrsv_pkg::REG_WIN_ABC,
              {8'hFF, 9'd300, 9'd0, 9'd100, 9'd5, 9'd511, 9'd0});
    write_reg(wrsv_pkg::REG_WIN_DEF,
              wrsv_pkg::CFG_DATA_W'({9'd10, 9'd400, 9'd300, 9'd200, 9'd50, 9'd50}));
    write_reg(wrsv_pkg::REG_SCALES_12, {31'h0200_0000, 31'(-(1 << 23))});
    write_reg(wrsv_pkg::REG_SCALES_34, {31'h3FFF_FFFF, 31'h4000_0000});
    write_reg(wrsv_pkg::REG_SCALE_5, wrsv_pkg::CFG_DATA_W'(31'h0100_0000));
    settings_count++;

    pending_words.push_back(make_word(0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
    pending_words.push_back(make_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 0, 4));
    pending_words.push_back(make_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h0001_0000, 5));
    // unit vector in every component, unit distance factor, across window edges
    pending_words.push_back(make_word(1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 16, 5));
    pending_words.push_back(make_word(1 << 20, -(1 << 20), 1 << 20, 1 << 20, 1 << 16, 99));
    pending_words.push_back(make_word(1 << 20, 1 << 20, -(1 << 20), 1 << 20, 1 << 16, 100));
    pending_words.push_back(make_word(1 << 20, 1 << 20, 1 << 20, -(1 << 20), 1 << 16, 199));
    pending_words.push_back(make_word(1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 16, 200));
    pending_words.push_back(make_word(3 << 18, -(5 << 17), 7 << 16, 1 << 19, 3 << 15, 299));
    pending_words.push_back(make_word(1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 16, 300));
    pending_words.push_back(make_word(1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 16, 511));
    pending_words.push_back(make_word(1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 16, 510));
    pending_words.push_back(make_word(1 << 20, 1 << 20, 1 << 20, 1 << 20, 1 << 16, 50));
    pending_words.push_back(make_word(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                      32'hAAAA_AAAA, 32'hAAAA_AAAA, 9'h155));
    pending_words.push_back(make_word(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                      32'h5555_5555, 32'h5555_5555, 9'h0AA));
    pending_words.push_back(make_word(-1, -1, -1, -1, 1, 250));
    pending_words.push_back(make_word(1 << 22, 1 << 21, 1 << 23, 1 << 20, 32'hFFFF_FFFF, 250));
    drain();

    // every register at all ones: all windows empty, so nothing runs
    idle_pct = 58;
    apply_settings(1'b1);
    repeat (10) pending_words.push_back(rand_word());
    drain();

    // random settings, cycling through the idle modes
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 58;
        default: idle_pct = 9;
      endcase
      apply_settings(1'b0);
      repeat (80) pending_words.push_back(rand_word());
      drain();
    end

    $display("checked %0d result words under %0d register settings", words_checked,
             settings_count);
    $display("%0d of them held a saturated field", saturated_count);
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
